### src/gsfr_pkg.sv
// types and fixed constants for the gas sensor frame receiver
// no dependencies; used by gas_sensor_frame_receiver_core
package gsfr_pkg;

    localparam int ByteW  = 8;
    localparam int CountW = 5;
    localparam int IdleW  = 16;
    localparam int ReadW  = 16;

    typedef logic [ByteW-1:0]  t_byte;
    typedef logic [CountW-1:0] t_count;
    typedef logic [IdleW-1:0]  t_idle;
    typedef logic [ReadW-1:0]  t_reading;

    localparam logic ReqByte = 1'b0;
    localparam logic ReqTick = 1'b1;

    localparam t_idle  IdleMax      = '1;
    localparam t_idle  GapReset     = 16'd200;
    // byte index of the reading's high and low halves
    localparam t_count IdxHigh      = 5'd4;
    localparam t_count IdxLow       = 5'd5;
    localparam t_count MinReadBytes = 5'd6;

endpackage

### src/gas_sensor_frame_receiver_core.sv
// gas sensor frame receiver: a frame-closing input transaction loads the result register
// throughput 1 item per unstalled cycle; state update and checksum test sit between the
// input handshake and the single output register, which stalls only when full and not taken
// synchronous active-low reset clears frame state, stored reading, output valid,
// and sets the idle gap to 200 ticks
// depends on gsfr_pkg
module gas_sensor_frame_receiver_core #(
    parameter int STORE_BYTES = 20
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [15:0]            i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_req_type,
    input  logic [7:0]             i_rx_byte,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_frame_ok,
    output logic [4:0]             o_frame_length,
    output logic [15:0]            o_reading_ppb
);

    localparam gsfr_pkg::t_count KeepMax = gsfr_pkg::t_count'(STORE_BYTES - 1);

    gsfr_pkg::t_idle    r_gap_ticks;
    gsfr_pkg::t_count   r_byte_count, n_byte_count;
    gsfr_pkg::t_byte    r_sum, n_sum;
    gsfr_pkg::t_byte    r_last, n_last;
    gsfr_pkg::t_byte    r_high, n_high;
    gsfr_pkg::t_byte    r_low, n_low;
    gsfr_pkg::t_idle    r_idle_count, n_idle_count;
    gsfr_pkg::t_reading r_stored, n_stored;

    logic                 r_out_valid, n_out_valid;
    logic                 r_frame_ok;
    gsfr_pkg::t_count     r_frame_length;
    gsfr_pkg::t_reading   r_reading;

    logic                 in_acc;
    logic                 close_frame;
    logic                 chk_ok;
    gsfr_pkg::t_idle      idle_inc;
    gsfr_pkg::t_byte      body;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;

    assign idle_inc = (r_idle_count < gsfr_pkg::IdleMax) ? r_idle_count + 1'b1 : r_idle_count;
    assign close_frame = in_acc && (i_req_type == gsfr_pkg::ReqTick)
                         && (r_byte_count != '0) && (idle_inc >= r_gap_ticks);
    // checksum body excludes the first and the last kept byte
    assign body   = (r_byte_count >= 5'd2) ? r_sum - r_last : '0;
    assign chk_ok = (gsfr_pkg::t_byte'(8'd0 - body) == r_last);

    always_comb begin
        n_byte_count = r_byte_count;
        n_sum        = r_sum;
        n_last       = r_last;
        n_high       = r_high;
        n_low        = r_low;
        n_idle_count = r_idle_count;
        n_stored     = r_stored;
        n_out_valid  = r_out_valid && !i_out_ready;
        if (in_acc) begin
            if (i_req_type == gsfr_pkg::ReqByte) begin
                n_idle_count = '0;
                if (r_byte_count < KeepMax) begin
                    if (r_byte_count != '0) begin
                        n_sum = r_sum + i_rx_byte;
                    end
                    if (r_byte_count == gsfr_pkg::IdxHigh) begin
                        n_high = i_rx_byte;
                    end
                    if (r_byte_count == gsfr_pkg::IdxLow) begin
                        n_low = i_rx_byte;
                    end
                    n_last       = i_rx_byte;
                    n_byte_count = r_byte_count + 1'b1;
                end
            end else if (r_byte_count != '0) begin
                n_idle_count = idle_inc;
                if (close_frame) begin
                    if (chk_ok && r_byte_count >= gsfr_pkg::MinReadBytes) begin
                        n_stored = {r_high, r_low};
                    end
                    n_out_valid  = 1'b1;
                    n_byte_count = '0;
                    n_sum        = '0;
                    n_last       = '0;
                    n_high       = '0;
                    n_low        = '0;
                    n_idle_count = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_ticks  <= gsfr_pkg::GapReset;
            r_byte_count <= '0;
            r_sum        <= '0;
            r_last       <= '0;
            r_high       <= '0;
            r_low        <= '0;
            r_idle_count <= '0;
            r_stored     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_gap_ticks <= i_cfg_data;
            end
            r_byte_count <= n_byte_count;
            r_sum        <= n_sum;
            r_last       <= n_last;
            r_high       <= n_high;
            r_low        <= n_low;
            r_idle_count <= n_idle_count;
            r_stored     <= n_stored;
            r_out_valid  <= n_out_valid;
        end
    end

    // result payload, loaded only when a frame closes
    always_ff @(posedge i_clk) begin
        if (close_frame) begin
            r_frame_ok     <= chk_ok;
            r_frame_length <= r_byte_count;
            r_reading      <= n_stored;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_frame_ok     = r_frame_ok;
    assign o_frame_length = r_frame_length;
    assign o_reading_ppb  = r_reading;

    a_byte_clears_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_req_type == gsfr_pkg::ReqByte) |=> r_idle_count == '0)
        else $error("idle count not cleared by byte");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= KeepMax)
        else $error("byte count beyond keep limit");

    a_close_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        close_frame |=> (r_byte_count == '0) && r_out_valid)
        else $error("frame close did not empty frame or raise result");

    a_empty_frame_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_byte_count == '0) |-> (r_idle_count == '0) && (r_sum == '0))
        else $error("empty frame holds stale idle count or sum");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |-> !close_frame)
        else $error("result overwritten while stalled");

endmodule
